// ===== src/srd_pkg.sv =====
// Shared width, controller states and command struct of the signed restoring divider.
package srd_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture operand magnitudes and signs
      logic step;     // one restoring iteration
      logic finish;   // sign fix-up into the output register
   } cmd_type;

endpackage

// ===== src/srd_ctrl.sv =====
// Controller state machine: sequences load, iterations and fix-up, and owns the handshakes.
module srd_ctrl
   import srd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             last_step;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_step = (cnt_ff == CNT_W'(WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_step) state_in = ST_FIX;
         end
         ST_FIX: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.finish  = 1'b0;
      cnt_in      = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            cnt_in     = '0;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         ST_FIX: begin
            cmd.finish = out_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // The result register stays full until the downstream side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/srd_datapath.sv =====
// Datapath: operand magnitudes, restoring iteration, sign fix-up and result register.
module srd_datapath
   import srd_pkg::*;
(
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder,
   output logic             divide_by_zero,
   output logic             overflow
);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-1:0] bm_ff, bm_in;
   logic             an_ff, an_in;
   logic             bn_ff, bn_in;
   logic             zero_ff, zero_in;

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic             dbz_ff, dbz_in;
   logic             ovf_ff, ovf_in;

   logic [WIDTH:0]   acc_sh;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] q_neg;
   logic [WIDTH-1:0] acc_neg;

   // The partial remainder stays below the divisor magnitude, so one extra bit
   // after the shift is enough; a clear top bit of the difference means no borrow.
   assign acc_sh  = {acc_ff, q_ff[WIDTH-1]};
   assign diff    = acc_sh - {1'b0, bm_ff};
   assign q_neg   = ~q_ff + WIDTH'(1);
   assign acc_neg = ~acc_ff + WIDTH'(1);

   always_comb begin
      acc_in  = acc_ff;
      q_in    = q_ff;
      bm_in   = bm_ff;
      an_in   = an_ff;
      bn_in   = bn_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         an_in   = dividend[WIDTH-1];
         bn_in   = divisor[WIDTH-1];
         q_in    = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
         bm_in   = divisor[WIDTH-1] ? (~divisor + WIDTH'(1)) : divisor;
         acc_in  = '0;
         zero_in = (divisor == '0);
      end else if (cmd.step) begin
         if (!diff[WIDTH]) begin
            acc_in = diff[WIDTH-1:0];
            q_in   = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            acc_in = acc_sh[WIDTH-1:0];
            q_in   = {q_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dbz_in = dbz_ff;
      ovf_in = ovf_ff;
      if (cmd.finish) begin
         dbz_in = zero_ff;
         ovf_in = 1'b0;
         priority if (zero_ff) begin
            quo_in = '0;
            rem_in = '0;
         end else begin
            rem_in = an_ff ? acc_neg : acc_ff;
            priority if (an_ff != bn_ff) begin
               quo_in = q_neg;
            end else if (q_ff[WIDTH-1]) begin
               // Most negative dividend over minus one: clamp to the largest positive value.
               quo_in = {1'b0, {(WIDTH-1){1'b1}}};
               ovf_in = 1'b1;
            end else begin
               quo_in = q_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      bm_ff   <= bm_in;
      an_ff   <= an_in;
      bn_ff   <= bn_in;
      zero_ff <= zero_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dbz_ff  <= dbz_in;
      ovf_ff  <= ovf_in;
   end

   assign quotient       = quo_ff;
   assign remainder      = rem_ff;
   assign divide_by_zero = dbz_ff;
   assign overflow       = ovf_ff;

endmodule

// ===== src/signed_restoring_divider.sv =====
// Top level of the signed restoring divider: stream ports, controller and datapath.
//
// Divides a signed dividend by a signed divisor and returns a quotient truncated
// toward zero, a remainder with the dividend's sign, and two flags. A zero
// divisor gives zero results with divide_by_zero set; the most negative
// dividend over minus one gives the largest positive quotient with overflow set.
// One request is in work at a time; from acceptance until the next request can be
// accepted it passes the acceptance in the idle state, one quotient bit per cycle
// in the single shared subtract-and-restore unit (32 iterations), and a sign
// fix-up state that writes the result register. The result register lets a new
// request start while the previous result waits; if that result is still not
// taken when the next fix-up is due, the divider holds in fix-up.
module signed_restoring_divider
   import srd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*WIDTH-1:0]   req_tdata,   // dividend, divisor
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*WIDTH-1:0]   rsp_tdata,   // quotient, remainder
   output logic [1:0]           rsp_tuser    // divide_by_zero, overflow
);

   cmd_type          cmd;
   logic [WIDTH-1:0] quotient;
   logic [WIDTH-1:0] remainder;
   logic             divide_by_zero;
   logic             overflow;

   srd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   srd_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .dividend       (req_tdata[WIDTH-1:0]),
      .divisor        (req_tdata[2*WIDTH-1:WIDTH]),
      .quotient       (quotient),
      .remainder      (remainder),
      .divide_by_zero (divide_by_zero),
      .overflow       (overflow)
   );

   assign rsp_tdata = {remainder, quotient};
   assign rsp_tuser = {overflow, divide_by_zero};

endmodule
